@@ hdl/tft_palette_pixel_feeder_macros.svh @@
// Assertion macros for the feeder top-level RTL.
`ifndef TFT_PALETTE_PIXEL_FEEDER_MACROS_SVH
`define TFT_PALETTE_PIXEL_FEEDER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TPF_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("tpf: invariant violated");

`define TPF_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpf: implication violated");

`else

`define TPF_ASSERT_ALWAYS(label, expr)

`define TPF_ASSERT_IMPLIES(label, ante, cons)

`endif

`endif

@@ hdl/tpf_pkg.sv @@
`default_nettype none

package tpf_pkg;

  localparam logic [1:0] REQ_WINDOW = 2'd0;
  localparam logic [1:0] REQ_BITMAP = 2'd1;
  localparam logic [1:0] REQ_SOLID  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] CFG_PALETTE_0 = 2'd0;
  localparam logic [1:0] CFG_PALETTE_1 = 2'd1;
  localparam logic [1:0] CFG_PALETTE_2 = 2'd2;
  localparam logic [1:0] CFG_PALETTE_3 = 2'd3;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam int unsigned NUM_WORDS = 4;

  localparam logic [4:0] LEN_WINDOW  = 5'd11;
  localparam logic [4:0] LEN_SOLID   = 5'd2;
  localparam logic [4:0] LEN_BITMAP  = 5'd8;
  localparam logic [4:0] LEN_DOUBLED = 5'd16;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] x_first;
    logic [15:0] y_first;
    logic [15:0] x_last;
    logic [15:0] y_last;
    logic [7:0]  pixel_byte;
    logic        doubled;
    logic [15:0] solid_color;
  } req_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       is_data;
    logic       release_select;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic                        window;
    logic                        single;
    logic                        doubled;
    logic [NUM_WORDS-1:0][15:0]  word;
  } job_t;

  typedef struct packed {
    logic       go;
    logic [3:0] step;
    logic [4:0] len;
  } back_stat_t;

endpackage

`default_nettype wire

@@ hdl/tft_palette_pixel_feeder.sv @@
// Palette pixel feeder for a serial TFT panel.
// Input queue side: present a request on req and raise push; it is taken at
// a clock edge with push high and full low. Window requests give 11 bytes,
// bitmap bytes give 8 (16 when doubled), solid pixels give 2; request
// code 3 is dropped without output.
// Output queue side: while empty is low, rsp holds the oldest byte with its
// command/data flag, chip-select release mark and last-of-request mark; it
// is taken at an edge with pop high. One byte leaves per cycle while pop
// stays high and the job queue is not empty. The first byte of a request
// passes the front register and the job queue before it is registered
// into the output register.
// Requests are expanded by a byte sequencer reading the head of a job queue
// of FIFO_DEPTH entries; the input stays open while that queue has room.
// When pop is held low, the output byte holds, the sequencer stops, the
// queue fills and full rises.
// Palette registers 0..3 are written through cfg_we/cfg_index/cfg_data while
// the block is idle; the user must see to it, the block has no check. Reset
// clears the palette to 0 and empties every stage; no clearing pass is needed.
`default_nettype none
`include "tft_palette_pixel_feeder_macros.svh"

module tft_palette_pixel_feeder #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire tpf_pkg::req_t req,
  output logic               empty,
  input  wire logic          pop,
  output tpf_pkg::rsp_t      rsp,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);
  import tpf_pkg::*;

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH+1);

  logic             job_valid;
  job_t             job;
  logic             fifo_full;
  logic             fifo_empty;
  logic [CNT_W-1:0] fifo_count;
  job_t             head;
  logic             head_pop;
  back_stat_t       stat;

  tpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fifo_full (fifo_full),
    .job_valid (job_valid),
    .job       (job)
  );

  tpf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_valid),
    .wr_job (job),
    .full   (fifo_full),
    .rd_en  (head_pop),
    .rd_job (head),
    .empty  (fifo_empty),
    .count  (fifo_count)
  );

  tpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!fifo_empty),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .rsp        (rsp),
    .stat       (stat)
  );

  `TPF_ASSERT_ALWAYS(a_fifo_bound, fifo_count <= CNT_W'(FIFO_DEPTH))
  `TPF_ASSERT_IMPLIES(a_full_holds_job, full, job_valid && fifo_full)
  `TPF_ASSERT_IMPLIES(a_step_in_range, stat.go, {1'b0, stat.step} < stat.len)
  `TPF_ASSERT_IMPLIES(a_pop_on_last, head_pop, stat.go && !fifo_empty)

endmodule

`default_nettype wire

@@ hdl/tpf_front.sv @@
`default_nettype none

module tpf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire tpf_pkg::req_t req,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          fifo_full,
  output logic               job_valid,
  output tpf_pkg::job_t      job
);
  import tpf_pkg::*;

  logic [15:0] pal0;
  logic [15:0] pal1;
  logic [15:0] pal2;
  logic [15:0] pal3;
  logic        advance;
  logic        accept;
  job_t        job_next;

  function automatic logic [15:0] pick(input logic [1:0] code, input logic [15:0] c0,
                                       input logic [15:0] c1, input logic [15:0] c2,
                                       input logic [15:0] c3);
    logic [15:0] r;
    case (code)
      2'd0: r = c0;
      2'd1: r = c1;
      2'd2: r = c2;
      default: r = c3;
    endcase
    return r;
  endfunction

  assign full    = job_valid && fifo_full;
  assign accept  = push && !full;
  assign advance = !job_valid || !fifo_full;

  always_comb begin
    job_next = '0;
    case (req.req_type)
      REQ_WINDOW: begin
        job_next.window  = 1'b1;
        job_next.word[0] = req.x_first;
        job_next.word[1] = req.x_last;
        job_next.word[2] = req.y_first;
        job_next.word[3] = req.y_last;
      end
      REQ_BITMAP: begin
        job_next.doubled = req.doubled;
        job_next.word[0] = pick(req.pixel_byte[7:6], pal0, pal1, pal2, pal3);
        job_next.word[1] = pick(req.pixel_byte[5:4], pal0, pal1, pal2, pal3);
        job_next.word[2] = pick(req.pixel_byte[3:2], pal0, pal1, pal2, pal3);
        job_next.word[3] = pick(req.pixel_byte[1:0], pal0, pal1, pal2, pal3);
      end
      REQ_SOLID: begin
        job_next.single  = 1'b1;
        job_next.word[0] = req.solid_color;
      end
      default: job_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pal0 <= '0;
      pal1 <= '0;
      pal2 <= '0;
      pal3 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PALETTE_0: pal0 <= cfg_data;
        CFG_PALETTE_1: pal1 <= cfg_data;
        CFG_PALETTE_2: pal2 <= cfg_data;
        CFG_PALETTE_3: pal3 <= cfg_data;
        default: pal0 <= pal0;
      endcase
    end
  end

  // drop the unused request code here
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (advance) begin
      job_valid <= accept && (req.req_type != REQ_UNUSED);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept) begin
      job <= job_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tpf_fifo.sv @@
`default_nettype none

module tpf_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire tpf_pkg::job_t            wr_job,
  output logic                          full,
  input  wire logic                     rd_en,
  output tpf_pkg::job_t                 rd_job,
  output logic                          empty,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import tpf_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/tpf_back.sv @@
`default_nettype none

module tpf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire tpf_pkg::job_t  head,
  output logic                head_pop,
  output logic                empty,
  input  wire logic           pop,
  output tpf_pkg::rsp_t       rsp,
  output tpf_pkg::back_stat_t stat
);
  import tpf_pkg::*;

  logic       out_valid;
  logic [3:0] step;
  logic [4:0] len;
  logic       go;
  logic       final_step;
  logic [1:0] widx;
  logic [15:0] w;
  rsp_t       rsp_next;

  always_comb begin
    if (head.window) begin
      len = LEN_WINDOW;
    end else if (head.single) begin
      len = LEN_SOLID;
    end else if (head.doubled) begin
      len = LEN_DOUBLED;
    end else begin
      len = LEN_BITMAP;
    end
  end

  assign go         = head_valid && (!out_valid || pop);
  assign final_step = ({1'b0, step} == (len - 5'd1));
  assign head_pop   = go && final_step;
  assign empty      = !out_valid;

  assign stat.go   = go;
  assign stat.step = step;
  assign stat.len  = len;

  always_comb begin
    widx     = head.doubled ? step[3:2] : step[2:1];
    w        = head.word[widx];
    rsp_next = '0;
    rsp_next.last = final_step;
    if (head.window) begin
      case (step)
        4'd0: begin
          rsp_next.spi_byte       = CMD_COLUMN_SET;
          rsp_next.release_select = 1'b1;
        end
        4'd5: begin
          rsp_next.spi_byte       = CMD_PAGE_SET;
          rsp_next.release_select = 1'b1;
        end
        4'd10: begin
          rsp_next.spi_byte       = CMD_MEMORY_WRITE;
          rsp_next.release_select = 1'b1;
        end
        4'd1: rsp_next = '{head.word[0][15:8], 1'b1, 1'b0, 1'b0};
        4'd2: rsp_next = '{head.word[0][7:0],  1'b1, 1'b1, 1'b0};
        4'd3: rsp_next = '{head.word[1][15:8], 1'b1, 1'b0, 1'b0};
        4'd4: rsp_next = '{head.word[1][7:0],  1'b1, 1'b1, 1'b0};
        4'd6: rsp_next = '{head.word[2][15:8], 1'b1, 1'b0, 1'b0};
        4'd7: rsp_next = '{head.word[2][7:0],  1'b1, 1'b1, 1'b0};
        4'd8: rsp_next = '{head.word[3][15:8], 1'b1, 1'b0, 1'b0};
        4'd9: rsp_next = '{head.word[3][7:0],  1'b1, 1'b1, 1'b0};
        default: rsp_next = '0;
      endcase
    end else begin
      rsp_next.spi_byte       = step[0] ? w[7:0] : w[15:8];
      rsp_next.is_data        = 1'b1;
      rsp_next.release_select = step[0];
      rsp_next.last           = final_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
        step      <= final_step ? '0 : step + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
